>>> sv/src_pkg.sv
`timescale 1ns / 1ps
// ----------------------------------------------------------------------------
// src_pkg
// Shared sizes, codes and structs of the source route cache.
// ----------------------------------------------------------------------------
package src_pkg;

    localparam int CACHE_ENTRIES = 64;
    localparam int MAX_HOPS      = 8;
    localparam int ADDR_W        = 32;
    localparam int CNT_W         = 4;
    localparam int IDX_W         = (CACHE_ENTRIES > 1) ? $clog2(CACHE_ENTRIES) : 1;
    localparam int HOP_W         = (MAX_HOPS > 1) ? $clog2(MAX_HOPS) : 1;

    typedef logic [ADDR_W-1:0] t_addr;
    typedef logic [MAX_HOPS-1:0][ADDR_W-1:0] t_row;

    typedef enum logic [1:0] {
        FN_LOOKUP,
        FN_ADD_FWD,
        FN_ADD_REV,
        FN_REMOVE
    } t_func;

    typedef enum logic [1:0] {
        ST_OK,
        ST_NO_ROUTE,
        ST_TOO_LONG
    } t_status;

    typedef enum logic [1:0] {
        CFG_OWN_ADDRESS,
        CFG_SUBNET_MASK,
        CFG_SUBNET_BASE,
        CFG_ROUTE_TIMEOUT
    } t_cfg;

    // entry read back from the store
    typedef struct packed {
        logic             valid;
        t_addr            dest;
        logic [CNT_W-1:0] hops;
        t_addr            stamp;
        t_row             row;
    } t_rd;

    // one write to the store
    typedef struct packed {
        logic             entry_we;
        logic             stamp_we;
        logic             clr;
        logic [IDX_W-1:0] addr;
        t_addr            dest;
        logic [CNT_W-1:0] hops;
        t_addr            stamp;
        t_row             row;
    } t_store_wr;

    // verdict of the compare unit on one entry
    typedef struct packed {
        logic  live;
        logic  expired;
        t_addr age;
        logic  better;
        logic  hit;
        logic  same;
        logic  older;
    } t_eval;

endpackage

>>> sv/src_store.sv
`timescale 1ns / 1ps
// ----------------------------------------------------------------------------
// src_store
// Entry memories (destination, hop count, stamp, hop row) with per-entry
// valid bits and a registered read port.
// ----------------------------------------------------------------------------
module src_store (
    input  logic                     i_clk,
    input  logic                     i_rst_n,
    input  logic [src_pkg::IDX_W-1:0] i_rd_addr,
    input  src_pkg::t_store_wr       i_wr,
    output src_pkg::t_rd             o_rd
);
    import src_pkg::*;

    t_addr            r_dest_mem  [CACHE_ENTRIES];
    logic [CNT_W-1:0] r_hops_mem  [CACHE_ENTRIES];
    t_addr            r_stamp_mem [CACHE_ENTRIES];
    t_row             r_row_mem   [CACHE_ENTRIES];
    logic [CACHE_ENTRIES-1:0] r_valid;
    t_rd              r_rd;

    // memory writes and registered read
    always_ff @(posedge i_clk) begin
        if (i_wr.entry_we) begin
            r_dest_mem[i_wr.addr] <= i_wr.dest;
            r_hops_mem[i_wr.addr] <= i_wr.hops;
            r_row_mem[i_wr.addr]  <= i_wr.row;
        end
        if (i_wr.stamp_we) begin
            r_stamp_mem[i_wr.addr] <= i_wr.stamp;
        end
        r_rd.valid <= r_valid[i_rd_addr];
        r_rd.dest  <= r_dest_mem[i_rd_addr];
        r_rd.hops  <= r_hops_mem[i_rd_addr];
        r_rd.stamp <= r_stamp_mem[i_rd_addr];
        r_rd.row   <= r_row_mem[i_rd_addr];
    end

    // valid bits, cleared at reset
    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_valid <= '0;
        end else if (i_wr.entry_we) begin
            r_valid[i_wr.addr] <= 1'b1;
        end else if (i_wr.clr) begin
            r_valid[i_wr.addr] <= 1'b0;
        end
    end

    assign o_rd = r_rd;

endmodule

>>> sv/src_eval.sv
`timescale 1ns / 1ps
// ----------------------------------------------------------------------------
// src_eval
// Shared compare unit: ages one entry and checks it against the current
// lookup, link or route under test.
// ----------------------------------------------------------------------------
module src_eval (
    input  src_pkg::t_rd              i_rd,
    input  src_pkg::t_addr            i_now,
    input  src_pkg::t_addr            i_timeout,
    input  src_pkg::t_addr            i_own,
    input  src_pkg::t_addr            i_key,
    input  src_pkg::t_addr            i_peer,
    input  logic [src_pkg::CNT_W-1:0] i_inh,
    input  src_pkg::t_row             i_route,
    input  logic                      i_found,
    input  logic [src_pkg::CNT_W-1:0] i_best_hops,
    input  src_pkg::t_addr            i_best_stamp,
    input  logic                      i_have_old,
    input  src_pkg::t_addr            i_old_age,
    output src_pkg::t_eval            o_ev
);
    import src_pkg::*;

    t_addr              age;
    t_addr              tie;
    logic               expired;
    logic               live;
    logic               dmatch;
    logic [CNT_W-1:0]   nh;
    t_addr [MAX_HOPS:0] prev;
    logic               hit;
    logic               same;

    always_comb begin
        age     = i_now - i_rd.stamp;
        tie     = i_best_stamp - i_rd.stamp;
        expired = (age >= i_timeout);
        live    = i_rd.valid && !expired;
        dmatch  = (i_rd.dest == i_key);
        nh      = (i_rd.hops > CNT_W'(MAX_HOPS)) ? CNT_W'(MAX_HOPS) : i_rd.hops;

        // path own_address, hops: hop j is preceded by prev[j]
        prev[0] = i_own;
        for (int j = 1; j <= MAX_HOPS; j++) begin
            prev[j] = i_rd.row[j-1];
        end
        hit = (prev[nh] == i_key) && (i_rd.dest == i_peer);
        for (int j = 0; j < MAX_HOPS; j++) begin
            if ((CNT_W'(j) < nh) && (prev[j] == i_key) && (i_rd.row[j] == i_peer)) begin
                hit = 1'b1;
            end
        end

        // same destination and hop list as the route under test
        same = dmatch && (i_rd.hops == i_inh);
        for (int j = 0; j < MAX_HOPS; j++) begin
            if ((CNT_W'(j) < i_inh) && (i_rd.row[j] != i_route[j])) begin
                same = 1'b0;
            end
        end

        o_ev.live    = live;
        o_ev.expired = expired;
        o_ev.age     = age;
        o_ev.better  = live && dmatch &&
                       (!i_found || (i_rd.hops < i_best_hops) ||
                        ((i_rd.hops == i_best_hops) && tie[ADDR_W-1]));
        o_ev.hit     = live && hit;
        o_ev.same    = live && same;
        o_ev.older   = live && (!i_have_old || (age > i_old_age));
    end

endmodule

>>> sv/source_route_cache.sv
`timescale 1ns / 1ps
// ----------------------------------------------------------------------------
// source_route_cache
// Source-route cache with lookup, hop-list add and link removal.
// ----------------------------------------------------------------------------
// Every lookup, removal and route install is one scan of the 64 entries
// through the shared compare unit, one entry a cycle. A lookup then returns
// one word per hop, or one word on a miss or zero-hop route. A final add word
// takes up to (MAX_HOPS + 1) scans, each with a write unless it finds an
// identical live route. One word at a time; busy meanwhile.
// Reset (synchronous, active low) clears all valid bits at once.
module source_route_cache (
    input  logic                      i_clk,
    input  logic                      i_rst_n,
    input  logic                      i_valid,
    output logic                      o_stall,
    input  logic [1:0]                i_func,
    input  logic [31:0]               i_addr,
    input  logic [31:0]               i_peer,
    input  logic                      i_last,
    input  logic [31:0]               i_now,
    output logic                      o_valid,
    input  logic                      i_stall,
    output logic [1:0]                o_status,
    output logic [3:0]                o_hop_count,
    output logic [31:0]               o_hop_addr,
    output logic                      o_end_of_run,
    input  logic                      i_cfg_we,
    input  logic [1:0]                i_cfg_idx,
    input  logic [31:0]               i_cfg_data
);
    import src_pkg::*;

    typedef enum logic [2:0] {
        S_IDLE,
        S_SCAN,
        S_LK_DONE,
        S_LK_ROW,
        S_STREAM,
        S_RESP,
        S_INS_NEXT,
        S_INS_WR
    } t_state;

    typedef enum logic [1:0] {
        MODE_LOOKUP,
        MODE_REMOVE,
        MODE_INSTALL
    } t_mode;

    localparam logic [IDX_W-1:0] LAST_IDX = IDX_W'(CACHE_ENTRIES - 1);

    t_state            r_state;
    t_mode             r_mode;
    t_addr             r_own, r_mask, r_base, r_timeout;

    // scan control
    logic [IDX_W-1:0]  r_ptr;
    logic              r_issue;
    logic              r_ev;
    logic [IDX_W-1:0]  r_ev_idx;
    logic              r_found;
    logic [IDX_W-1:0]  r_best;
    logic [CNT_W-1:0]  r_best_hops;
    t_addr             r_best_stamp;
    logic              r_have_free;
    logic [IDX_W-1:0]  r_free_idx;
    logic              r_have_old;
    logic [IDX_W-1:0]  r_old_idx;
    t_addr             r_old_age;

    // word under work
    t_addr             r_key, r_peer, r_now, r_fin;
    logic [CNT_W-1:0]  r_inh;
    t_row              r_route;
    logic [CNT_W-1:0]  r_n;
    logic [CNT_W-1:0]  r_pi;

    // staged hop list, in order and newest first
    t_row              r_stg;
    t_row              r_stg_rev;
    logic [CNT_W-1:0]  r_stg_cnt;
    logic              r_stg_over;

    // result stream
    t_row              r_orow;
    logic [CNT_W-1:0]  r_k;
    t_status           r_rs_status;
    logic [CNT_W-1:0]  r_rs_count;
    logic              r_o_valid;
    t_status           r_o_status;
    logic [CNT_W-1:0]  r_o_count;
    t_addr             r_o_hop;
    logic              r_o_end;

    logic [IDX_W-1:0]  rd_addr;
    t_store_wr         st_wr;
    t_rd               rd;
    t_eval             ev;
    logic              out_free;
    logic              cand_ok;
    t_addr             cand_dest;
    logic [CNT_W-1:0]  cand_nh;
    logic              stream_end;
    logic              scan_stop;

    src_store u_store (
        .i_clk     (i_clk),
        .i_rst_n   (i_rst_n),
        .i_rd_addr (rd_addr),
        .i_wr      (st_wr),
        .o_rd      (rd)
    );

    src_eval u_eval (
        .i_rd         (rd),
        .i_now        (r_now),
        .i_timeout    (r_timeout),
        .i_own        (r_own),
        .i_key        (r_key),
        .i_peer       (r_peer),
        .i_inh        (r_inh),
        .i_route      (r_route),
        .i_found      (r_found),
        .i_best_hops  (r_best_hops),
        .i_best_stamp (r_best_stamp),
        .i_have_old   (r_have_old),
        .i_old_age    (r_old_age),
        .o_ev         (ev)
    );

    assign out_free   = !r_o_valid || !i_stall;
    assign stream_end = ((r_k + CNT_W'(1)) == r_best_hops);
    // install scan ends early on an identical live route
    assign scan_stop  = r_ev && (r_mode == MODE_INSTALL) && ev.same;

    // next route to install: each prefix, then the in-subnet destination
    always_comb begin
        cand_ok   = 1'b0;
        cand_dest = '0;
        cand_nh   = r_pi;
        if (r_pi < r_n) begin
            cand_ok   = 1'b1;
            cand_dest = r_route[r_pi[HOP_W-1:0]];
        end else if ((r_pi == r_n) && ((r_fin & r_mask) == r_base)) begin
            cand_ok   = 1'b1;
            cand_dest = r_fin;
            cand_nh   = r_n;
        end
    end

    // store address and writes
    always_comb begin
        rd_addr        = (r_state == S_SCAN) ? r_ptr : r_best;
        st_wr          = '0;
        st_wr.addr     = r_ev_idx;
        st_wr.stamp    = r_now;
        st_wr.dest     = r_key;
        st_wr.hops     = r_inh;
        st_wr.row      = r_route;
        case (r_state)
            S_SCAN: begin
                if (r_ev) begin
                    st_wr.clr = (rd.valid && ev.expired) ||
                                ((r_mode == MODE_REMOVE) && ev.hit);
                    st_wr.stamp_we = (r_mode == MODE_INSTALL) && ev.same;
                end
            end
            S_LK_DONE: begin
                st_wr.addr     = r_best;
                st_wr.stamp_we = r_found;
            end
            S_INS_WR: begin
                st_wr.addr     = r_have_free ? r_free_idx : r_old_idx;
                st_wr.entry_we = 1'b1;
                st_wr.stamp_we = 1'b1;
            end
            default: begin
            end
        endcase
    end

    // sequencer
    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_state     <= S_IDLE;
            r_mode      <= MODE_LOOKUP;
            r_own       <= '0;
            r_mask      <= '0;
            r_base      <= '0;
            r_timeout   <= 32'd3000;
            r_stg_cnt   <= '0;
            r_stg_over  <= 1'b0;
            r_o_valid   <= 1'b0;
            r_issue     <= 1'b0;
            r_ev        <= 1'b0;
        end else begin
            // output word taken and no new one loaded this cycle
            if (r_o_valid && !i_stall && (r_state != S_STREAM) && (r_state != S_RESP)) begin
                r_o_valid <= 1'b0;
            end

            // configuration writes
            if (i_cfg_we) begin
                case (t_cfg'(i_cfg_idx))
                    CFG_OWN_ADDRESS:   r_own     <= i_cfg_data;
                    CFG_SUBNET_MASK:   r_mask    <= i_cfg_data;
                    CFG_SUBNET_BASE:   r_base    <= i_cfg_data;
                    CFG_ROUTE_TIMEOUT: r_timeout <= i_cfg_data;
                    default: begin
                    end
                endcase
            end

            case (r_state)
                S_IDLE: begin
                    if (i_valid) begin
                        r_now  <= i_now;
                        r_key  <= i_addr;
                        r_peer <= i_peer;
                        r_ptr       <= '0;
                        r_issue     <= 1'b1;
                        r_ev        <= 1'b0;
                        r_found     <= 1'b0;
                        r_have_free <= 1'b0;
                        r_have_old  <= 1'b0;
                        case (t_func'(i_func))
                            FN_LOOKUP: begin
                                r_mode  <= MODE_LOOKUP;
                                r_state <= S_SCAN;
                            end
                            FN_REMOVE: begin
                                r_mode  <= MODE_REMOVE;
                                r_state <= S_SCAN;
                            end
                            default: begin
                                if (!i_last) begin
                                    // stage one hop
                                    if (r_stg_cnt < CNT_W'(MAX_HOPS)) begin
                                        r_stg[r_stg_cnt[HOP_W-1:0]] <= i_addr;
                                        r_stg_rev[0] <= i_addr;
                                        for (int j = 1; j < MAX_HOPS; j++) begin
                                            r_stg_rev[j] <= r_stg_rev[j-1];
                                        end
                                        r_stg_cnt   <= r_stg_cnt + CNT_W'(1);
                                        r_rs_status <= ST_OK;
                                        r_rs_count  <= r_stg_cnt + CNT_W'(1);
                                    end else begin
                                        r_stg_over  <= 1'b1;
                                        r_rs_status <= ST_TOO_LONG;
                                        r_rs_count  <= r_stg_cnt;
                                    end
                                    r_state <= S_RESP;
                                end else begin
                                    // final destination word
                                    r_rs_count <= r_stg_cnt;
                                    r_stg_cnt  <= '0;
                                    r_stg_over <= 1'b0;
                                    if (r_stg_over) begin
                                        r_rs_status <= ST_TOO_LONG;
                                        r_state     <= S_RESP;
                                    end else begin
                                        r_route <= (t_func'(i_func) == FN_ADD_REV) ?
                                                   r_stg_rev : r_stg;
                                        r_n         <= r_stg_cnt;
                                        r_fin       <= i_addr;
                                        r_pi        <= '0;
                                        r_rs_status <= ST_OK;
                                        r_state     <= S_INS_NEXT;
                                    end
                                end
                            end
                        endcase
                    end
                end

                S_SCAN: begin
                    // issue reads one entry ahead of the compare
                    if (r_issue && !scan_stop) begin
                        r_ev     <= 1'b1;
                        r_ev_idx <= r_ptr;
                        if (r_ptr == LAST_IDX) begin
                            r_issue <= 1'b0;
                        end else begin
                            r_ptr <= r_ptr + IDX_W'(1);
                        end
                    end else begin
                        r_ev <= 1'b0;
                    end
                    if (r_ev) begin
                        if (ev.better) begin
                            r_found      <= 1'b1;
                            r_best       <= r_ev_idx;
                            r_best_hops  <= rd.hops;
                            r_best_stamp <= rd.stamp;
                        end
                        if (!ev.live && !r_have_free) begin
                            r_have_free <= 1'b1;
                            r_free_idx  <= r_ev_idx;
                        end
                        if (ev.older) begin
                            r_have_old <= 1'b1;
                            r_old_idx  <= r_ev_idx;
                            r_old_age  <= ev.age;
                        end
                        if (scan_stop) begin
                            r_issue <= 1'b0;
                            r_pi    <= r_pi + CNT_W'(1);
                            r_state <= S_INS_NEXT;
                        end else if (r_ev_idx == LAST_IDX) begin
                            case (r_mode)
                                MODE_LOOKUP: r_state <= S_LK_DONE;
                                MODE_REMOVE: begin
                                    r_rs_status <= ST_OK;
                                    r_rs_count  <= '0;
                                    r_state     <= S_RESP;
                                end
                                default:     r_state <= S_INS_WR;
                            endcase
                        end
                    end
                end

                S_LK_DONE: begin
                    if (!r_found) begin
                        r_rs_status <= ST_NO_ROUTE;
                        r_rs_count  <= '0;
                        r_state     <= S_RESP;
                    end else if (r_best_hops == '0) begin
                        r_rs_status <= ST_OK;
                        r_rs_count  <= '0;
                        r_state     <= S_RESP;
                    end else begin
                        r_state <= S_LK_ROW;
                    end
                end

                S_LK_ROW: begin
                    r_orow  <= rd.row;
                    r_k     <= '0;
                    r_state <= S_STREAM;
                end

                // one word per hop of the found route
                S_STREAM: begin
                    if (out_free) begin
                        r_o_valid  <= 1'b1;
                        r_o_status <= ST_OK;
                        r_o_count  <= r_best_hops;
                        r_o_hop    <= r_orow[r_k[HOP_W-1:0]];
                        r_o_end    <= stream_end;
                        if (stream_end) begin
                            r_state <= S_IDLE;
                        end else begin
                            r_k <= r_k + CNT_W'(1);
                        end
                    end
                end

                S_RESP: begin
                    if (out_free) begin
                        r_o_valid  <= 1'b1;
                        r_o_status <= r_rs_status;
                        r_o_count  <= r_rs_count;
                        r_o_hop    <= '0;
                        r_o_end    <= 1'b1;
                        r_state    <= S_IDLE;
                    end
                end

                S_INS_NEXT: begin
                    if (!cand_ok) begin
                        r_state <= S_RESP;
                    end else if (cand_dest == '0) begin
                        r_pi <= r_pi + CNT_W'(1);
                    end else begin
                        r_key       <= cand_dest;
                        r_inh       <= cand_nh;
                        r_mode      <= MODE_INSTALL;
                        r_ptr       <= '0;
                        r_issue     <= 1'b1;
                        r_ev        <= 1'b0;
                        r_found     <= 1'b0;
                        r_have_free <= 1'b0;
                        r_have_old  <= 1'b0;
                        r_state     <= S_SCAN;
                    end
                end

                S_INS_WR: begin
                    r_pi    <= r_pi + CNT_W'(1);
                    r_state <= S_INS_NEXT;
                end

                default: r_state <= S_IDLE;
            endcase
        end
    end

    assign o_stall      = (r_state != S_IDLE);
    assign o_valid      = r_o_valid;
    assign o_status     = r_o_status;
    assign o_hop_count  = r_o_count;
    assign o_hop_addr   = r_o_hop;
    assign o_end_of_run = r_o_end;

endmodule

>>> sv/src_checker.sv
`timescale 1ns / 1ps
// ----------------------------------------------------------------------------
// src_checker
// Port-level checks on the source route cache result stream.
// ----------------------------------------------------------------------------
module src_checker (
    input logic        i_clk,
    input logic        i_rst_n,
    input logic        i_valid,
    input logic        o_stall,
    input logic        o_valid,
    input logic        i_stall,
    input logic [1:0]  o_status,
    input logic [3:0]  o_hop_count,
    input logic [31:0] o_hop_addr,
    input logic        o_end_of_run
);
    import src_pkg::*;

    // a stalled word holds
    a_hold: assert property (@(posedge i_clk) disable iff (!i_rst_n)
        o_valid && i_stall |=> o_valid && $stable(o_hop_addr) && $stable(o_status))
        else $error("stalled result word changed");

    // an accepted word keeps the block busy next cycle
    a_busy: assert property (@(posedge i_clk) disable iff (!i_rst_n)
        i_valid && !o_stall |=> o_stall)
        else $error("input taken while idle after accept");

    // error results are single words
    a_err_single: assert property (@(posedge i_clk) disable iff (!i_rst_n)
        o_valid && (o_status != ST_OK) |-> o_end_of_run)
        else $error("error result not last of run");

    // a miss carries no hops
    a_miss: assert property (@(posedge i_clk) disable iff (!i_rst_n)
        o_valid && (o_status == ST_NO_ROUTE) |-> (o_hop_count == 4'd0) && (o_hop_addr == '0))
        else $error("miss with hop data");

    // zero hops means a single word
    a_zero: assert property (@(posedge i_clk) disable iff (!i_rst_n)
        o_valid && (o_hop_count == 4'd0) |-> o_end_of_run)
        else $error("zero-hop result not last of run");

endmodule

bind source_route_cache src_checker u_src_checker (.*);
